// ----- design/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache tag store: field widths,
// controller states and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int KEY_W            = 16;
   localparam int CNT_W            = 16;
   localparam int SLOT_W           = 6;

   localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFE;
   localparam logic [CNT_W:0]   BEST_INIT = 17'h10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic do_clear;
      logic fill_only;
      logic init_scan;
      logic read;
      logic check;
      logic write;
   } lfu_cmd_type;

   typedef struct packed {
      logic req_clear;
      logic fill_zero;
      logic match;
      logic last;
   } lfu_status_type;

endpackage

// ----- design/lfu_cache_tag_store_unit.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_tag_store_unit
// Fully associative least-frequently-used tag store with CAPACITY entries.
//
// Request: drive req_cmd/req_key with start; the request is taken at a rising
// edge where start is high and busy is low. req_cmd high clears the store.
// Response: rsp_valid is high for exactly one cycle with hit, slot, evicted,
// evicted_key and use_count; the receiver cannot stall it.
// Sequence: a clear goes from the accepting edge straight to the response.
// A lookup reads one entry per read/check state pair from the
// registered-read entry RAM (address state, compare state), scanning the
// entries up to and including a hit, or up to the fill level on a miss; a
// lookup into an empty store skips the scan. The victim search shares that
// pass; the entry write follows the scan and precedes the response.
// One request is in flight at a time; the next is taken in the cycle
// after the response.
// Reset clears the fill level and the controller; entry contents are not
// cleared and are only read once rewritten.
// ----------------------------------------------------------------------------
module lfu_cache_tag_store_unit
   import lfu_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [KEY_W-1:0]  req_key,
   output logic              rsp_valid,
   output logic              rsp_hit,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic              rsp_evicted,
   output logic [KEY_W-1:0]  rsp_evicted_key,
   output logic [CNT_W-1:0]  rsp_use_count
);

   lfu_cmd_type    cmd;
   lfu_status_type status;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lfu_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .cmd             (cmd),
      .status          (status),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .rsp_use_count   (rsp_use_count)
   );

endmodule

// ----- design/lfu_ram.sv -----
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lfu_datapath.sv -----
// ----------------------------------------------------------------------------
// lfu_datapath
// Entry RAM, fill level, scan index, running minimum and result registers.
// One entry is compared per read/check pair; the victim search runs in the
// same pass as the hit search.
// ----------------------------------------------------------------------------
module lfu_datapath
   import lfu_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_cmd,
   input  logic [KEY_W-1:0]   req_key,
   input  lfu_cmd_type        cmd,
   output lfu_status_type     status,
   output logic               rsp_hit,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic               rsp_evicted,
   output logic [KEY_W-1:0]   rsp_evicted_key,
   output logic [CNT_W-1:0]   rsp_use_count
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [CNT_W:0]    best_cnt_ff, best_cnt_in;
   logic [KEY_W-1:0]  best_key_ff, best_key_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic              evicted_ff, evicted_in;
   logic [KEY_W-1:0]  ev_key_ff, ev_key_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [KEY_W+CNT_W-1:0] rd_data;
   logic [KEY_W-1:0]       rd_key;
   logic [CNT_W-1:0]       rd_cnt;
   logic [CNT_W-1:0]       cnt_inc;
   logic                   new_min;
   logic                   match;
   logic                   last;

   lfu_ram #(
      .WIDTH (KEY_W + CNT_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (slot_ff),
      .wr_data ({key_ff, count_ff}),
      .rd_en   (cmd.read),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_key  = rd_data[KEY_W+CNT_W-1:CNT_W];
   assign rd_cnt  = rd_data[CNT_W-1:0];
   assign cnt_inc = (rd_cnt < COUNT_MAX) ? rd_cnt + CNT_W'(1) : rd_cnt;
   assign new_min = {1'b0, rd_cnt} < best_cnt_ff;
   assign match   = rd_key == key_ff;
   assign last    = (FILL_W'(idx_ff) + FILL_W'(1)) == fill_ff;

   assign status.req_clear = req_cmd;
   assign status.fill_zero = fill_ff == '0;
   assign status.match     = match;
   assign status.last      = last;

   always_comb begin
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      key_in      = key_ff;
      best_idx_in = best_idx_ff;
      best_cnt_in = best_cnt_ff;
      best_key_in = best_key_ff;
      hit_in      = hit_ff;
      slot_in     = slot_ff;
      evicted_in  = evicted_ff;
      ev_key_in   = ev_key_ff;
      count_in    = count_ff;

      if (cmd.load) begin
         key_in = req_key;
      end

      if (cmd.do_clear) begin
         fill_in    = '0;
         hit_in     = 1'b0;
         slot_in    = '0;
         evicted_in = 1'b0;
         ev_key_in  = '0;
         count_in   = '0;
      end

      if (cmd.fill_only) begin
         hit_in     = 1'b0;
         slot_in    = fill_ff[IDX_W-1:0];
         fill_in    = fill_ff + FILL_W'(1);
         evicted_in = 1'b0;
         ev_key_in  = '0;
         count_in   = '0;
      end

      if (cmd.init_scan) begin
         idx_in      = '0;
         best_idx_in = '0;
         best_cnt_in = BEST_INIT;
         best_key_in = '0;
      end

      if (cmd.check) begin
         idx_in = idx_ff + IDX_W'(1);
         if (match) begin
            hit_in     = 1'b1;
            slot_in    = idx_ff;
            evicted_in = 1'b0;
            ev_key_in  = '0;
            count_in   = cnt_inc;
         end else begin
            if (new_min) begin
               best_idx_in = idx_ff;
               best_cnt_in = {1'b0, rd_cnt};
               best_key_in = rd_key;
            end
            if (last) begin
               hit_in   = 1'b0;
               count_in = '0;
               if (fill_ff < FILL_MAX) begin
                  slot_in    = fill_ff[IDX_W-1:0];
                  fill_in    = fill_ff + FILL_W'(1);
                  evicted_in = 1'b0;
                  ev_key_in  = '0;
               end else begin
                  slot_in    = new_min ? idx_ff : best_idx_ff;
                  evicted_in = 1'b1;
                  ev_key_in  = new_min ? rd_key : best_key_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      key_ff      <= key_in;
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
      best_key_ff <= best_key_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      evicted_ff  <= evicted_in;
      ev_key_ff   <= ev_key_in;
      count_ff    <= count_in;
   end

   assign rsp_hit         = hit_ff;
   assign rsp_slot        = SLOT_W'(slot_ff);
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = ev_key_ff;
   assign rsp_use_count   = count_ff;

endmodule

// ----- design/lfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfu_ctrl
// Controller: accepts a request, sequences the scan, the entry write and
// the one-cycle response strobe.
// ----------------------------------------------------------------------------
module lfu_ctrl
   import lfu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  lfu_status_type status,
   output lfu_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (status.req_clear) begin
                  cmd.do_clear = 1'b1;
                  state_in     = ST_RESP;
               end else if (status.fill_zero) begin
                  cmd.fill_only = 1'b1;
                  state_in      = ST_WRITE;
               end else begin
                  cmd.init_scan = 1'b1;
                  state_in      = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.match || status.last) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LFU cache tag store. Lookups and clears are
// sent through the start/busy handshake with random idle gaps. Each accepted
// request runs through an in-bench predictor of the tag store. Every response
// strobe is checked field by field against the oldest predicted response.
// Directed tests cover the key extremes, clears, fill order, ties in the
// victim choice and repeated hits on one entry. Random phases then mix small,
// large and fully random key pools with occasional clears.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lfu_pkg::*;

   localparam int CAP   = DEFAULT_CAPACITY;
   localparam int LIMIT = 3_000_000;
   localparam int DRAIN = 2 * CAP + 12;

   localparam bit CMD_LOOKUP = 1'b0;
   localparam bit CMD_CLEAR  = 1'b1;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              evicted;
      logic [KEY_W-1:0]  evicted_key;
      logic [CNT_W-1:0]  use_count;
   } tag_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_cmd = 1'b0;
   logic [KEY_W-1:0]  req_key = '0;
   logic              rsp_valid;
   logic              rsp_hit;
   logic [SLOT_W-1:0] rsp_slot;
   logic              rsp_evicted;
   logic [KEY_W-1:0]  rsp_evicted_key;
   logic [CNT_W-1:0]  rsp_use_count;

   logic [KEY_W-1:0] tag_keys [CAP];
   logic [CNT_W-1:0] tag_counts [CAP];
   int               tag_fill = 0;

   tag_result_type results_due [$];
   tag_result_type want;
   int             mismatches = 0;
   int             responses = 0;
   int             cycle_count = 0;
   bit             idling_on = 1'b1;

   lfu_cache_tag_store_unit #(
      .CAPACITY(CAP)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_hit(rsp_hit),
      .rsp_slot(rsp_slot),
      .rsp_evicted(rsp_evicted),
      .rsp_evicted_key(rsp_evicted_key),
      .rsp_use_count(rsp_use_count)
   );

   always #2 clock = ~clock;

   function automatic tag_result_type apply_tag_request(input bit cmd,
                                                        input logic [KEY_W-1:0] key);
      tag_result_type  r;
      int              i;
      int              idx;
      logic [CNT_W:0]  best_cnt;
      r   = '0;
      idx = -1;
      if (cmd == CMD_CLEAR) begin
         tag_fill = 0;
         return r;
      end
      for (i = 0; i < tag_fill; i++) begin
         if (idx < 0 && tag_keys[i] == key) begin
            idx = i;
         end
      end
      if (idx >= 0) begin
         if (tag_counts[idx] < COUNT_MAX) begin
            tag_counts[idx] = tag_counts[idx] + 1'b1;
         end
         r.hit       = 1'b1;
         r.slot      = idx[SLOT_W-1:0];
         r.use_count = tag_counts[idx];
         return r;
      end
      if (tag_fill < CAP) begin
         idx = tag_fill;
         tag_fill++;
      end else begin
         idx      = 0;
         best_cnt = BEST_INIT;
         for (i = 0; i < CAP; i++) begin
            if ({1'b0, tag_counts[i]} < best_cnt) begin
               best_cnt = {1'b0, tag_counts[i]};
               idx      = i;
            end
         end
         r.evicted     = 1'b1;
         r.evicted_key = tag_keys[idx];
      end
      tag_keys[idx]   = key;
      tag_counts[idx] = '0;
      r.slot          = idx[SLOT_W-1:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!idling_on) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Hold the request until taken, then predict its response and idle.
   task automatic issue_request(input bit cmd, input logic [KEY_W-1:0] key);
      int gap;
      req_cmd <= cmd;
      req_key <= key;
      start   <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      results_due.push_back(apply_tag_request(cmd, key));
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on response %0d: %s", responses, what);
         $display("  expected hit=%0d slot=%0d evicted=%0d evicted_key=%h use_count=%0d",
                  want.hit, want.slot, want.evicted, want.evicted_key, want.use_count);
         $display("  actual   hit=%0d slot=%0d evicted=%0d evicted_key=%h use_count=%0d",
                  rsp_hit, rsp_slot, rsp_evicted, rsp_evicted_key, rsp_use_count);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         responses++;
         if (results_due.size() == 0) begin
            want = '0;
            note_mismatch("no request outstanding");
         end else begin
            want = results_due.pop_front();
            if (rsp_hit !== want.hit || rsp_slot !== want.slot ||
                rsp_evicted !== want.evicted || rsp_evicted_key !== want.evicted_key ||
                rsp_use_count !== want.use_count) begin
               note_mismatch("field mismatch");
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic test_basic_lookups();
      idling_on = 1'b1;
      issue_request(CMD_CLEAR, 16'h1234);
      issue_request(CMD_LOOKUP, 16'h0000);
      issue_request(CMD_LOOKUP, 16'hFFFF);
      issue_request(CMD_LOOKUP, 16'hAAAA);
      issue_request(CMD_LOOKUP, 16'h5555);
      issue_request(CMD_LOOKUP, 16'h0000);
      issue_request(CMD_LOOKUP, 16'hFFFF);
      issue_request(CMD_LOOKUP, 16'hFFFF);
      issue_request(CMD_LOOKUP, 16'h5555);
      issue_request(CMD_CLEAR, 16'hFFFF);
      issue_request(CMD_LOOKUP, 16'hFFFF);
      issue_request(CMD_LOOKUP, 16'h0000);
      issue_request(CMD_LOOKUP, 16'h0000);
      issue_request(CMD_CLEAR, 16'h0000);
   endtask

   task automatic test_fill_and_evict();
      int i;
      idling_on = 1'b0;
      for (i = 0; i < CAP; i++) begin
         issue_request(CMD_LOOKUP, KEY_W'(16'h0100 + i));
      end
      issue_request(CMD_LOOKUP, 16'h0100);
      issue_request(CMD_LOOKUP, 16'hC000);
      issue_request(CMD_LOOKUP, 16'hC001);
      issue_request(CMD_LOOKUP, 16'hC000);
      for (i = 1; i < CAP; i++) begin
         if (i != 40) begin
            issue_request(CMD_LOOKUP, tag_keys[i]);
         end
      end
      issue_request(CMD_LOOKUP, 16'hD000);
      issue_request(CMD_LOOKUP, 16'hD001);
   endtask

   task automatic test_repeated_hits();
      int n;
      idling_on = 1'b0;
      issue_request(CMD_CLEAR, 16'h0000);
      issue_request(CMD_LOOKUP, 16'hBEEF);
      for (n = 0; n < 8; n++) begin
         issue_request(CMD_LOOKUP, 16'hBEEF);
      end
   endtask

   task automatic test_random_traffic();
      int               phase;
      int               n;
      int               mode;
      int               pool_size;
      logic [KEY_W-1:0] pool [$];
      logic [KEY_W-1:0] key;
      for (phase = 0; phase < 8; phase++) begin
         mode      = $urandom_range(0, 3);
         idling_on = ($urandom_range(0, 3) != 0);
         case (mode)
            0: pool_size = 6;
            1: pool_size = 80;
            3: pool_size = 66;
            default: pool_size = 0;
         endcase
         pool.delete();
         for (n = 0; n < pool_size; n++) begin
            pool.push_back(KEY_W'($urandom_range(0, 65535)));
         end
         if (pool_size > 0 && $urandom_range(0, 1) == 1) begin
            pool[0] = 16'h0000;
            pool[1] = 16'hFFFF;
         end
         for (n = 0; n < 50; n++) begin
            if ($urandom_range(0, 49) == 0) begin
               issue_request(CMD_CLEAR, KEY_W'($urandom_range(0, 65535)));
            end else begin
               if (pool_size == 0) begin
                  key = KEY_W'($urandom_range(0, 65535));
               end else if (mode == 3 && $urandom_range(0, 9) < 6) begin
                  key = pool[$urandom_range(0, 7)];
               end else begin
                  key = pool[$urandom_range(0, pool_size - 1)];
               end
               issue_request(CMD_LOOKUP, key);
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_basic_lookups();
      test_fill_and_evict();
      test_repeated_hits();
      test_random_traffic();
      start <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
